// ===== rtl/p2rx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package p2rx_pkg;
  localparam int RING_DEPTH = 256;
  localparam int CMD_DEPTH  = 8;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CMD_AW     = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CW     = $clog2(CMD_DEPTH + 1);
  localparam int QDEPTH     = 2;

  localparam logic [7:0] DEV_ACK    = 8'hFA;
  localparam logic [7:0] DEV_RESEND = 8'hFE;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic CFG_AUX_PRESENT = 1'b0;
  localparam logic CFG_OPEN_MASK   = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    op_t        op;
    logic       port;
    logic       drop;
    logic [7:0] data;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_RD   = 2'd1,
    BK_DONE = 2'd2
  } bk_state_t;
endpackage
`default_nettype wire

// ===== rtl/p2rx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module p2rx_front
  import p2rx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_op,
  input  wire logic       in_aux_flag,
  input  wire logic       in_port,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       q_pop,
  output logic            q_valid,
  output item_t           q_item
);
  logic       aux_present_r;
  logic [1:0] open_mask_r;
  item_t      q_r [QDEPTH];
  logic [1:0] q_cnt_r;
  logic       q_wp_r, q_rp_r;
  item_t      cls;
  logic       push;

  assign cfg_ready = 1'b1;
  assign busy      = (q_cnt_r == 2'(QDEPTH));
  assign push      = start && !busy;
  assign q_valid   = (q_cnt_r != 2'd0);
  assign q_item    = q_r[q_rp_r];

  always_comb begin
    cls.op   = op_t'(in_op);
    cls.data = in_data_byte;
    cls.port = in_port;
    cls.drop = 1'b0;
    if (op_t'(in_op) == OP_RX) begin
      cls.port = aux_present_r && in_aux_flag;
      cls.drop = !open_mask_r[cls.port];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aux_present_r <= 1'b0;
      open_mask_r   <= 2'b00;
      q_cnt_r       <= 2'd0;
      q_wp_r        <= 1'b0;
      q_rp_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_AUX_PRESENT: aux_present_r <= cfg_data[0];
          CFG_OPEN_MASK:   open_mask_r   <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (push) begin
        q_r[q_wp_r] <= cls;
        q_wp_r      <= !q_wp_r;
      end
      if (q_pop) q_rp_r <= !q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/p2rx_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module p2rx_back
  import p2rx_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_strobe,
  output logic       out_tx_valid,
  output logic       out_tx_to_aux,
  output logic [7:0] out_tx_byte,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic       out_write_accepted,
  output logic       out_cmd_space_freed,
  output logic       out_rx_stored,
  output logic [7:0] out_readable_count,
  output logic       out_writable
);
  bk_state_t state_r, state_nxt;
  item_t     it_r;

  logic [7:0]         ring_mem [2*RING_DEPTH];
  logic [7:0]         cmd_mem  [2*CMD_DEPTH];
  logic [RING_AW-1:0] head_r [2];
  logic [RING_AW-1:0] tail_r [2];
  logic [CMD_CW-1:0]  sent_r [2];
  logic [CMD_CW-1:0]  cnt_r  [2];
  logic [7:0]         ring_rd_r, cmd_rd_r;

  logic               p;
  logic [CMD_CW-1:0]  sent, cnt, sent_inc;
  logic               pend, is_ack, ack_end, full_end, store, tx;
  logic               do_push, do_pop, do_cmdw;
  logic [RING_AW-1:0] tail_inc, head_inc;
  logic [CMD_AW-1:0]  cmd_ra;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_RD;
      BK_RD:   state_nxt = BK_DONE;
      BK_DONE: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign q_pop = (state_r == BK_IDLE) && q_valid;

  // decode on the captured item
  always_comb begin
    p        = it_r.port;
    sent     = sent_r[p];
    cnt      = cnt_r[p];
    sent_inc = sent + 1'b1;
    tail_inc = tail_r[p] + 1'b1;
    head_inc = head_r[p] + 1'b1;
    pend     = (sent < cnt);
    is_ack   = (it_r.data == DEV_ACK);
    full_end = is_ack && (sent_inc >= CMD_CW'(CMD_DEPTH));
    ack_end  = is_ack && (full_end || sent_inc == cnt);
    store    = 1'b0;
    tx       = 1'b0;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_cmdw  = 1'b0;
    cmd_ra   = sent[CMD_AW-1:0];
    case (it_r.op)
      OP_RX: begin
        if (!it_r.drop) begin
          if (pend) begin
            store = ack_end || !(is_ack || it_r.data == DEV_RESEND);
            tx    = !store;
            if (is_ack) cmd_ra = sent_inc[CMD_AW-1:0];
          end else begin
            store = 1'b1;
          end
        end
        do_push = store;
      end
      OP_WRITE: begin
        do_cmdw = (cnt < CMD_CW'(CMD_DEPTH));
        tx      = do_cmdw && (cnt == '0);
        cmd_ra  = '0;
      end
      OP_READ:  do_pop = (head_r[p] != tail_r[p]);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_RD) begin
      ring_rd_r <= ring_mem[{p, head_r[p]}];
      cmd_rd_r  <= cmd_mem[{p, cmd_ra}];
    end
    if (state_r == BK_DONE && do_push) ring_mem[{p, tail_r[p]}] <= it_r.data;
    if (state_r == BK_DONE && do_cmdw) cmd_mem[{p, cnt[CMD_AW-1:0]}] <= it_r.data;
  end

  always_ff @(posedge clk) begin
    if (q_pop) it_r <= q_item;
    if (!rst_n) begin
      state_r <= BK_IDLE;
      for (int i = 0; i < 2; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        sent_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_DONE) begin
        if (do_push) begin
          tail_r[p] <= tail_inc;
          if (tail_inc == head_r[p]) head_r[p] <= head_inc;
        end
        if (do_pop) head_r[p] <= head_inc;
        if (do_cmdw) cnt_r[p] <= cnt + 1'b1;
        if (it_r.op == OP_RX && !it_r.drop && pend && is_ack) begin
          if (ack_end) begin
            sent_r[p] <= '0;
            cnt_r[p]  <= '0;
          end else begin
            sent_r[p] <= sent_inc;
          end
        end
      end
    end
  end

  // outputs formed from the post-step view of the captured item
  always_comb begin
    logic [RING_AW-1:0] h, t;
    logic [CMD_CW-1:0]  c;
    h = head_r[p];
    t = tail_r[p];
    if (do_push) begin
      t = tail_inc;
      if (tail_inc == head_r[p]) h = head_inc;
    end
    if (do_pop) h = head_inc;
    c = cnt;
    if (do_cmdw) c = cnt + 1'b1;
    if (it_r.op == OP_RX && !it_r.drop && pend && ack_end) c = '0;
    out_strobe          = (state_r == BK_DONE);
    // hold the tx, read and rx-stored valid flags low between strobes
    out_tx_valid        = out_strobe && tx;
    out_tx_to_aux       = tx && p;
    out_tx_byte         = tx ? (do_cmdw ? it_r.data : cmd_rd_r) : 8'h00;
    out_read_valid      = out_strobe && do_pop;
    out_read_byte       = do_pop ? ring_rd_r : 8'h00;
    out_write_accepted  = do_cmdw;
    out_cmd_space_freed = it_r.op == OP_RX && !it_r.drop && pend && full_end;
    out_rx_stored       = out_strobe && do_push;
    out_readable_count  = 8'(RING_AW'(t - h));
    out_writable        = (c < CMD_CW'(CMD_DEPTH));
  end
endmodule
`default_nettype wire

// ===== rtl/ps2_two_port_rx_ring_cmd_ack_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake          | payload
// input    | start / busy       | in_op, in_aux_flag, in_port, in_data_byte
// result   | out_strobe         | out_tx_* .. out_writable
// config   | cfg_valid/ready    | cfg_index, cfg_data
// An item passes through the back-end steps pick, memory read and update;
// the back end takes a new item only after it is done with the last.
// A two-entry queue lets start be taken while the back end works.
// Reset clears pointers, counts, state and config; memories and data registers are not cleared.
// Results cannot be stalled: each shows for one cycle on out_strobe.
module ps2_two_port_rx_ring_cmd_ack_top
  import p2rx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_op,
  input  wire logic       in_aux_flag,
  input  wire logic       in_port,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  output logic            out_strobe,
  output logic            out_tx_valid,
  output logic            out_tx_to_aux,
  output logic [7:0]      out_tx_byte,
  output logic            out_read_valid,
  output logic [7:0]      out_read_byte,
  output logic            out_write_accepted,
  output logic            out_cmd_space_freed,
  output logic            out_rx_stored,
  output logic [7:0]      out_readable_count,
  output logic            out_writable
);
  logic  q_pop, q_valid;
  item_t q_item;

  p2rx_front u_front (
    .clk, .rst_n, .start, .busy, .in_op, .in_aux_flag, .in_port, .in_data_byte,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .q_pop, .q_valid, .q_item
  );

  p2rx_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .out_strobe, .out_tx_valid,
    .out_tx_to_aux, .out_tx_byte, .out_read_valid, .out_read_byte,
    .out_write_accepted, .out_cmd_space_freed, .out_rx_stored,
    .out_readable_count, .out_writable
  );

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_read_valid && (out_tx_valid || out_rx_stored)))
    else $error("read overlaps other result");
  a_pop_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> ##2 out_strobe)
    else $error("popped item gave no result");
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_strobe |-> !out_tx_valid && !out_read_valid && !out_rx_stored)
    else $error("result flags outside strobe");
endmodule
`default_nettype wire
